// File: rtl/airbrake_flight_sequencer_assert.svh
// Assertion macros for the air-brake flight sequencer.
// Needs a clk and an active-low rst_n in the including scope.
`ifndef AIRBRAKE_FLIGHT_SEQUENCER_ASSERT_SVH
`define AIRBRAKE_FLIGHT_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define ABF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ABF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/abf_pkg.sv
// Shared types and constants for the air-brake flight sequencer.
// No dependencies.
package abf_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int NOW_W         = 32;
    localparam int ACCEL_W       = 16;
    localparam int CFG_W         = 16;
    localparam int CYC_W         = 8;
    localparam int IDX_W         = 3;

    typedef enum logic [2:0] {
        PH_READY = 3'd0,
        PH_MOTOR = 3'd1,
        PH_OPEN  = 3'd2,
        PH_CLOSE = 3'd3,
        PH_END   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_MOTOR  = 3'd1,
        EV_FALSE  = 3'd2,
        EV_OPEN   = 3'd3,
        EV_CLOSE  = 3'd4,
        EV_SAFETY = 3'd5
    } event_t;

    // register indexes on the config port
    localparam logic [IDX_W-1:0] REG_ACCEL_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] REG_FALSE_START_MS  = 3'd1;
    localparam logic [IDX_W-1:0] REG_BURN_MS         = 3'd2;
    localparam logic [IDX_W-1:0] REG_OPEN_MS         = 3'd3;
    localparam logic [IDX_W-1:0] REG_CLOSE_MS        = 3'd4;
    localparam logic [IDX_W-1:0] REG_SAFETY_MS       = 3'd5;
    localparam logic [IDX_W-1:0] REG_MAX_CYCLES      = 3'd6;

    // register reset values
    localparam logic [CFG_W-1:0] RST_ACCEL_THRESHOLD = 16'd16384;
    localparam logic [CFG_W-1:0] RST_FALSE_START_MS  = 16'd500;
    localparam logic [CFG_W-1:0] RST_BURN_MS         = 16'd2500;
    localparam logic [CFG_W-1:0] RST_OPEN_MS         = 16'd800;
    localparam logic [CFG_W-1:0] RST_CLOSE_MS        = 16'd800;
    localparam logic [CFG_W-1:0] RST_SAFETY_MS       = 16'd1000;
    localparam logic [CYC_W-1:0] RST_MAX_CYCLES      = 8'd3;

endpackage

// File: rtl/airbrake_flight_sequencer.sv
// An input beat passes the input register, then the result register, to become its result beat.
// Throughput: one tick per cycle unless the output stalls; the phase update is a single
//   compare-and-select pass between the input and result registers; state updates with the result.
// Reset (rst_n, async, low): phase ready, start time 0, cycle count 0, brakes retracted,
//   config registers at their defaults, both pipeline registers empty.
module airbrake_flight_sequencer #(
    parameter int TIME_BITS = abf_pkg::TIME_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // input tick: [31:0] now_ms, [47:32] accel_sample (signed)
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [47:0]               s_axis_tdata,
    // result: [2:0] phase, [3] brake_drive, [6:4] event_code, [7] zero
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,
    // register write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [abf_pkg::IDX_W-1:0] cfg_index,
    input  logic [abf_pkg::CFG_W-1:0] cfg_data
);
    import abf_pkg::*;

    `include "airbrake_flight_sequencer_assert.svh"

    // ------------------------------------------------------------------
    // Config registers, always ready; the user must write them only while idle (not enforced here).
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] accel_threshold_reg;
    logic [CFG_W-1:0] false_start_ms_reg;
    logic [CFG_W-1:0] burn_ms_reg;
    logic [CFG_W-1:0] open_ms_reg;
    logic [CFG_W-1:0] close_ms_reg;
    logic [CFG_W-1:0] safety_ms_reg;
    logic [CYC_W-1:0] max_cycles_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_threshold_reg <= RST_ACCEL_THRESHOLD;
            false_start_ms_reg  <= RST_FALSE_START_MS;
            burn_ms_reg         <= RST_BURN_MS;
            open_ms_reg         <= RST_OPEN_MS;
            close_ms_reg        <= RST_CLOSE_MS;
            safety_ms_reg       <= RST_SAFETY_MS;
            max_cycles_reg      <= RST_MAX_CYCLES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ACCEL_THRESHOLD: accel_threshold_reg <= cfg_data;
                REG_FALSE_START_MS:  false_start_ms_reg  <= cfg_data;
                REG_BURN_MS:         burn_ms_reg         <= cfg_data;
                REG_OPEN_MS:         open_ms_reg         <= cfg_data;
                REG_CLOSE_MS:        close_ms_reg        <= cfg_data;
                REG_SAFETY_MS:       safety_ms_reg       <= cfg_data;
                REG_MAX_CYCLES:      max_cycles_reg      <= cfg_data[CYC_W-1:0];
                default:             ;   // unmapped index: dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register. Time is held at TIME_BITS: truncated or zero-extended.
    // ------------------------------------------------------------------
    logic                 in_valid_reg;
    logic [TIME_BITS-1:0] in_now_reg;
    logic [ACCEL_W-1:0]   in_accel_reg;
    logic [TIME_BITS-1:0] now_t;
    logic                 advance;
    logic                 out_valid_reg;
    logic [7:0]           out_data_reg;

    generate
        if (TIME_BITS <= NOW_W)
        begin : g_now_trunc
            assign now_t = s_axis_tdata[TIME_BITS-1:0];
        end
        else
        begin : g_now_ext
            assign now_t = {{(TIME_BITS-NOW_W){1'b0}}, s_axis_tdata[NOW_W-1:0]};
        end
    endgenerate

    // the tick in the input register moves on when the result slot is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_now_reg   <= now_t;
            in_accel_reg <= s_axis_tdata[NOW_W +: ACCEL_W];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and the single decision pass
    // ------------------------------------------------------------------
    phase_t               phase_reg, phase_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [CYC_W-1:0]     cycle_count_reg, cycle_count_next;
    logic                 brake_level_reg, brake_level_next;
    event_t               event_code;

    logic [ACCEL_W:0]     mag;       // 17 bits: -32768 gives 32768
    logic [TIME_BITS-1:0] elapsed;   // wraps mod 2^TIME_BITS
    logic                 mag_above, mag_below;
    logic                 t_false, t_burn, t_open, t_close, t_safety;
    logic                 cycles_left;

    always_comb
    begin
        if (in_accel_reg[ACCEL_W-1])
            mag = {1'b1, {ACCEL_W{1'b0}}} - {1'b0, in_accel_reg};
        else
            mag = {1'b0, in_accel_reg};
    end

    assign elapsed     = in_now_reg - start_reg;
    assign mag_above   = mag > {1'b0, accel_threshold_reg};
    assign mag_below   = mag < {1'b0, accel_threshold_reg};
    assign t_false     = elapsed < {{(TIME_BITS-CFG_W){1'b0}}, false_start_ms_reg};
    assign t_burn      = elapsed > {{(TIME_BITS-CFG_W){1'b0}}, burn_ms_reg};
    assign t_open      = elapsed > {{(TIME_BITS-CFG_W){1'b0}}, open_ms_reg};
    assign t_close     = elapsed > {{(TIME_BITS-CFG_W){1'b0}}, close_ms_reg};
    assign t_safety    = elapsed > {{(TIME_BITS-CFG_W){1'b0}}, safety_ms_reg};
    assign cycles_left = cycle_count_reg < max_cycles_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_READY:
                if (mag_above)
                    phase_next = PH_MOTOR;
            PH_MOTOR:
                if (mag_below && t_false)
                    phase_next = PH_READY;
                else if (t_burn)
                    phase_next = PH_OPEN;
            PH_OPEN:
                if (t_open && cycles_left)
                    phase_next = PH_CLOSE;
                else if (t_safety)
                    phase_next = PH_END;
            PH_CLOSE:
                if (t_close)
                    phase_next = PH_OPEN;
            default:
                phase_next = PH_END;
        endcase
    end

    // event, timer restart, cycle count and brake level
    always_comb
    begin
        event_code       = EV_NONE;
        start_next       = start_reg;
        cycle_count_next = cycle_count_reg;
        brake_level_next = brake_level_reg;
        case (phase_reg)
            PH_READY:
                if (mag_above)
                begin
                    event_code = EV_MOTOR;
                    start_next = in_now_reg;
                end
            PH_MOTOR:
                if (mag_below && t_false)
                begin
                    event_code = EV_FALSE;   // start time and count kept
                end
                else if (t_burn)
                begin
                    event_code = EV_OPEN;
                    start_next = in_now_reg;
                end
            PH_OPEN:
            begin
                brake_level_next = 1'b1;
                if (t_open && cycles_left)
                begin
                    event_code       = EV_CLOSE;
                    start_next       = in_now_reg;
                    cycle_count_next = cycle_count_reg + CYC_W'(1);
                end
                else if (t_safety)
                begin
                    event_code = EV_SAFETY;
                end
            end
            PH_CLOSE:
            begin
                brake_level_next = 1'b0;
                if (t_close)
                begin
                    event_code = EV_OPEN;
                    start_next = in_now_reg;
                end
            end
            default:
                ;   // end: everything held
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_READY;
            start_reg       <= '0;
            cycle_count_reg <= '0;
            brake_level_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            start_reg       <= start_next;
            cycle_count_reg <= cycle_count_next;
            brake_level_reg <= brake_level_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {1'b0, event_code, brake_level_next, phase_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ABF_ASSERT_NEXT(a_end_final, phase_reg == PH_END, phase_reg == PH_END,
        "end phase left without reset")
    `ABF_ASSERT_NOW(a_count_step, !$stable(cycle_count_reg),
        cycle_count_reg == $past(cycle_count_reg) + 8'd1, "cycle count moved by other than one")
    `ABF_ASSERT_NEXT(a_open_drives, advance && phase_reg == PH_OPEN, brake_level_reg,
        "open tick left brakes retracted")
    `ABF_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, s_axis_tready,
        "input stalled with empty result slot")

endmodule

// File: tb/airbrake_flight_sequencer_test.sv
// Self-checking testbench for the air-brake flight sequencer.
// Holds a tick-by-tick phase tracker and drives the stream and register ports.
// Depends on abf_pkg and the airbrake_flight_sequencer RTL.

class flight_phase_tracker;

    typedef struct packed {
        abf_pkg::phase_t phase;
        logic            brake;
        abf_pkg::event_t code;
    } flight_report_t;

    // register copies
    logic [15:0] thresh;
    logic [15:0] false_start;
    logic [15:0] burn;
    logic [15:0] open_hold;
    logic [15:0] close_hold;
    logic [15:0] safety;
    logic [7:0]  cycle_limit;

    // sequencer state
    abf_pkg::phase_t phase;
    logic [31:0]     start_ms;
    logic [7:0]      cycles;
    logic            brake;

    flight_report_t expected_reports[$];
    int             errors;

    function new();
        thresh      = abf_pkg::RST_ACCEL_THRESHOLD;
        false_start = abf_pkg::RST_FALSE_START_MS;
        burn        = abf_pkg::RST_BURN_MS;
        open_hold   = abf_pkg::RST_OPEN_MS;
        close_hold  = abf_pkg::RST_CLOSE_MS;
        safety      = abf_pkg::RST_SAFETY_MS;
        cycle_limit = abf_pkg::RST_MAX_CYCLES;
        phase       = abf_pkg::PH_READY;
        start_ms    = '0;
        cycles      = '0;
        brake       = 1'b0;
        errors      = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
        case (idx)
            abf_pkg::REG_ACCEL_THRESHOLD: thresh      = data;
            abf_pkg::REG_FALSE_START_MS:  false_start = data;
            abf_pkg::REG_BURN_MS:         burn        = data;
            abf_pkg::REG_OPEN_MS:         open_hold   = data;
            abf_pkg::REG_CLOSE_MS:        close_hold  = data;
            abf_pkg::REG_SAFETY_MS:       safety      = data;
            abf_pkg::REG_MAX_CYCLES:      cycle_limit = data[7:0];
            default: ;
        endcase
    endfunction

    // one accepted tick -> one expected report
    function void note_tick(logic [31:0] now, logic [15:0] accel);
        logic [31:0]     elapsed;
        logic [16:0]     mag;
        abf_pkg::event_t code;
        flight_report_t  rep;
        elapsed = now - start_ms;
        mag     = accel[15] ? (17'h10000 - {1'b0, accel}) : {1'b0, accel};
        code    = abf_pkg::EV_NONE;
        case (phase)
            abf_pkg::PH_READY:
                if (mag > {1'b0, thresh})
                begin
                    phase    = abf_pkg::PH_MOTOR;
                    start_ms = now;
                    code     = abf_pkg::EV_MOTOR;
                end
            abf_pkg::PH_MOTOR:
                if (mag < {1'b0, thresh} && elapsed < {16'd0, false_start})
                begin
                    // start time and cycle count stay as they are
                    phase = abf_pkg::PH_READY;
                    code  = abf_pkg::EV_FALSE;
                end
                else if (elapsed > {16'd0, burn})
                begin
                    phase    = abf_pkg::PH_OPEN;
                    start_ms = now;
                    code     = abf_pkg::EV_OPEN;
                end
            abf_pkg::PH_OPEN:
            begin
                brake = 1'b1;
                if (elapsed > {16'd0, open_hold} && cycles < cycle_limit)
                begin
                    cycles   = cycles + 8'd1;
                    phase    = abf_pkg::PH_CLOSE;
                    start_ms = now;
                    code     = abf_pkg::EV_CLOSE;
                end
                else if (elapsed > {16'd0, safety})
                begin
                    phase = abf_pkg::PH_END;
                    code  = abf_pkg::EV_SAFETY;
                end
            end
            abf_pkg::PH_CLOSE:
            begin
                brake = 1'b0;
                if (elapsed > {16'd0, close_hold})
                begin
                    phase    = abf_pkg::PH_OPEN;
                    start_ms = now;
                    code     = abf_pkg::EV_OPEN;
                end
            end
            default: phase = abf_pkg::PH_END;
        endcase
        rep.phase = phase;
        rep.brake = brake;
        rep.code  = code;
        expected_reports.push_back(rep);
    endfunction

    function void check_result(logic [7:0] beat);
        flight_report_t want;
        if (expected_reports.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("result beat 0x%02h with nothing expected", beat);
        end
        else
        begin
            want = expected_reports.pop_front();
            if (beat[2:0] !== want.phase || beat[3] !== want.brake
                || beat[6:4] !== want.code || beat[7] !== 1'b0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected phase %0d brake %0d event %0d,",
                             want.phase, want.brake, want.code,
                             " got phase %0d brake %0d event %0d pad %0d",
                             beat[2:0], beat[3], beat[6:4], beat[7]);
            end
        end
    endfunction

    function int pending();
        return expected_reports.size();
    endfunction

endclass

module airbrake_flight_sequencer_test;

    import abf_pkg::*;

    // no-accept cycles before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // receiver hold-off length for the backpressure test
    localparam int HOLD_CYCLES    = 80;
    // quiet cycles after the last result (pipeline is two deep)
    localparam int DRAIN_CYCLES   = 8;
    // index past the last register; writes there must be ignored
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    // directed ticks start just below the 32-bit wrap
    localparam logic [31:0] DIRECT_BASE = 32'hFFFF_FF00;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [47:0]       s_axis_tdata  = '0;   // [31:0] now_ms, [47:32] accel_sample
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;         // [2:0] phase, [3] brake, [6:4] event, [7] pad
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_W-1:0]  cfg_data      = '0;

    // calm: both sides stop idling; hold_request: receiver stalls for a long stretch
    bit          calm         = 1'b0;
    bit          hold_request = 1'b0;
    logic [31:0] flight_clock = '0;

    flight_phase_tracker sb = new();

    airbrake_flight_sequencer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ~35% idle per cycle unless a calm stretch is running
    function automatic bit roll_idle();
        return !calm && ($urandom_range(0, 99) < 35);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off on request so
    // the pipeline fills and s_axis_tready has to drop.
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else
                m_axis_tready <= !roll_idle();
        end
    end

    // every accepted result beat goes straight to the tracker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Hang detector: any beat on any channel restarts the count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers. All called at a falling edge and return at one; valid is
    // left high after a beat so back-to-back beats need no second NBA.
    // ------------------------------------------------------------------
    task automatic drive_tick(input logic [31:0] now, input logic [15:0] accel);
        while (roll_idle())
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {accel, now};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_tick(now, accel);
        flight_clock = now;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    // max_cycles takes a full 16-bit word so upper-bit truncation is exercised
    task automatic load_settings(input logic [15:0] thr, input logic [15:0] fs,
                                 input logic [15:0] brn, input logic [15:0] opn,
                                 input logic [15:0] cls, input logic [15:0] saf,
                                 input logic [15:0] cyc_word);
        write_reg(REG_ACCEL_THRESHOLD, thr);
        write_reg(REG_FALSE_START_MS, fs);
        write_reg(REG_BURN_MS, brn);
        write_reg(REG_OPEN_MS, opn);
        write_reg(REG_CLOSE_MS, cls);
        write_reg(REG_SAFETY_MS, saf);
        write_reg(REG_MAX_CYCLES, cyc_word);
        cfg_valid <= 1'b0;
    endtask

    // stop offering, wait for every expected result, then let the pipe settle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Random flights. The next tick is shaped from the tracked phase:
    // mostly a plausible flight (boost above threshold in ready, mixed
    // levels in motor, time hitting timer edges), with time jumps, wraps
    // and raw random samples mixed in as noise.
    // ------------------------------------------------------------------
    task automatic run_flights(input int count, input int step_max);
        logic [31:0] now;
        logic [31:0] span;
        logic [15:0] accel;
        int          roll;
        int          mag;
        int          v;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
            begin
                // land one below, on, or one past the live timer edge
                case (sb.phase)
                    PH_MOTOR: span = $urandom_range(0, 1) ? sb.burn : sb.false_start;
                    PH_OPEN:  span = $urandom_range(0, 1) ? sb.open_hold : sb.safety;
                    PH_CLOSE: span = sb.close_hold;
                    default:  span = '0;
                endcase
                now = sb.start_ms + span + $urandom_range(0, 2) - 1;
            end
            else if (roll < 22)
                now = $urandom;                  // jump anywhere, often backwards
            else if (roll < 30)
                now = flight_clock;              // repeated time stamp
            else
                now = flight_clock + $urandom_range(0, step_max);

            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                case ($urandom_range(0, 4))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = 0;
                    3:       v = sb.thresh;      // exactly on threshold
                    default: v = -int'(sb.thresh);
                endcase
            end
            else if (roll < 60 && sb.phase == PH_READY)
            begin
                // boost: magnitude strictly above threshold, or 32768 for thresholds of 32768 and up
                if (sb.thresh >= 16'h8000)
                    mag = 32768;
                else
                    mag = $urandom_range(int'(sb.thresh) + 1, 32768);
                v = $urandom_range(0, 1) ? -mag : mag;
            end
            else if (roll < 60 && sb.phase == PH_MOTOR && $urandom_range(0, 1))
            begin
                // burnout: magnitude strictly below threshold (zero when the threshold is zero)
                mag = (sb.thresh == 16'd0) ? 0 : $urandom_range(0, int'(sb.thresh) - 1);
                v = $urandom_range(0, 1) ? -mag : mag;
            end
            else
                v = $urandom;
            accel = v[15:0];
            drive_tick(now, accel);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed flight at reset settings, straddling the 32-bit time wrap.
        drive_tick(DIRECT_BASE + 32'd0,    16'sd0);          // idle on the pad
        drive_tick(DIRECT_BASE + 32'd10,   16'sd16384);      // on threshold: no launch
        drive_tick(DIRECT_BASE + 32'd20,  -16'sd16384);
        drive_tick(DIRECT_BASE + 32'd30,   16'h8000);        // most negative: magnitude 32768
        drive_tick(DIRECT_BASE + 32'd100,  16'sd0);          // false start
        drive_tick(DIRECT_BASE + 32'd200,  16'sd16385);      // relaunch
        drive_tick(DIRECT_BASE + 32'd699,  16'sd16384);      // not below threshold
        drive_tick(DIRECT_BASE + 32'd700, -16'sd5);          // false-start window just closed
        drive_tick(DIRECT_BASE + 32'd2700, 16'sd0);          // burn edge, not past it
        drive_tick(DIRECT_BASE + 32'd2701, 16'sd0);          // open
        drive_tick(DIRECT_BASE + 32'd3501, 16'sd32767);      // open edge, brakes now out
        drive_tick(DIRECT_BASE + 32'd3502, 16'sd0);          // close, cycle 1
        drive_tick(DIRECT_BASE + 32'd4302, 16'sd0);
        drive_tick(DIRECT_BASE + 32'd4303, 16'sd0);          // reopen
        drive_tick(DIRECT_BASE + 32'd5104, 16'sd0);          // close, cycle 2
        drive_tick(DIRECT_BASE + 32'd5905, 16'sd0);
        drive_tick(DIRECT_BASE + 32'd6706, 16'sd0);          // close, cycle 3
        drive_tick(DIRECT_BASE + 32'd7507, 16'sd0);
        drive_tick(DIRECT_BASE + 32'd8308, 16'h8000);        // cycles used up, safety not yet
        drive_tick(DIRECT_BASE + 32'd8309, 16'sd32767);
        settle();

        // Bogus index must not disturb anything; cycle word upper byte is dropped.
        write_reg(REG_UNUSED, 16'hFFFF);
        load_settings(16'd8000, 16'd30, 16'd60, 16'd20, 16'd25, 16'd200, 16'hABFF);
        run_flights(90, 20);
        settle();

        // Zero threshold and timers, safety at maximum: a tick with nonzero magnitude or elapsed time moves the phase.
        load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd65535, 16'd200);
        run_flights(60, 3);
        settle();

        // Threshold 32768 and timers at their maximum: no tick launches from ready.
        load_settings(16'd32768, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
                      16'd65535, 16'd255);
        run_flights(50, 30000);
        settle();

        // Back-to-back traffic with a long receiver stall, then random idling again.
        load_settings(16'd20000, 16'd100, 16'd300, 16'd150, 16'd150, 16'd400, 16'd255);
        calm         = 1'b1;
        hold_request = 1'b1;
        run_flights(70, 120);
        calm = 1'b0;
        run_flights(80, 120);
        settle();

        // No cycles allowed: open goes straight to end after safety, which is final.
        load_settings(16'd1000, 16'd50, 16'd100, 16'd50, 16'd50, 16'd300, 16'h0100);
        run_flights(80, 40);
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: airbrake_flight_sequencer.f
+incdir+rtl
rtl/abf_pkg.sv
rtl/airbrake_flight_sequencer.sv
tb/airbrake_flight_sequencer_test.sv
